>>> hw/rtl/dpq_pkg.sv
// Shared widths, codes and payload types of the depth pixel quantizer.
// No dependencies; every other file of the block refers to it by scoped names.
package dpq_pkg;

	// Quantizer resolution and the width of the code field on the port.
	localparam int CODE_BITS = 12;
	localparam int CODE_W = 12;
	localparam logic [CODE_BITS-1:0] CODE_MAX = {CODE_BITS{1'b1}};

	localparam int RAW_W = 32;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;

	// Depth in signed Q16.16; binary32 input saturates at 2^46.
	localparam int D_W = 48;
	localparam int MAG_W = 47;
	localparam int X_W = 48;

	// Fixed-point log2: integer part and fraction bits.
	localparam int N_W = 6;
	localparam int LOG_FRAC = 28;
	localparam int L_W = N_W + LOG_FRAC;
	localparam int LOG_LAT = LOG_FRAC + 2;

	// Ratio denominator and the product numerator * CODE_MAX.
	localparam int DEN_W = L_W;
	localparam int P_W = DEN_W + CODE_BITS;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NONFINITE = 3'd1,
		ST_RANGE     = 3'd2,
		ST_LOGARG    = 3'd3,
		ST_BADRANGE  = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE_FORMAT = 3'd0,
		CFG_RANGE_LOW     = 3'd1,
		CFG_RANGE_HIGH    = 3'd2,
		CFG_LOG_OFFSET    = 3'd3,
		CFG_CLIP_ENABLE   = 3'd4,
		CFG_LOG_MODE      = 3'd5
	} cfg_index_t;

	// How the final code is formed once the ratio is clamped.
	typedef enum logic [1:0] {
		CK_ZERO = 2'd0,
		CK_FULL = 2'd1,
		CK_DIV  = 2'd2
	} code_kind_t;

	typedef struct packed {
		logic       last;
		status_t    status;
		code_kind_t kind;
	} tag_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		status_t           status;
		logic              last;
	} res_t;

endpackage

>>> hw/rtl/depth_pixel_quantizer.sv
// Top level of the depth pixel quantizer: configuration registers, range checks,
// three log units, the ratio divider and the output skid. Depends on dpq_pkg and all dpq_ modules.
//
// Usage. Depth pixels arrive on the input channel (raw_sample, last_pixel) under
// in_valid/in_stall, one request per pixel in raster order. Each pixel yields exactly
// one result request (code, status, frame_end) on the output channel under
// out_valid/out_stall. A request moves at a clock edge where valid is high and stall low.
// Throughput is one pixel per clock while in_stall is low: every stage is a register stage and an item may
// enter in every cycle that is not stalled. On its way to out_valid a pixel passes through, with the
// default widths, two conversion stages, one check stage, the log unit (two
// normalising stages plus one squaring stage per fraction bit), two ratio stages,
// one divider stage per code bit plus rounding, and the output register.
// The user writes configuration via cfg_we/cfg_index/cfg_data while idle; the block does not check.
// Reset restores the register defaults (linear mode, 0 to 10 m, clipping on) and
// empties the pipeline; there is no clearing pass.
// When the receiver stalls, the output register holds its request and one more result
// drops into a skid register; in_stall, driven straight from that skid register, then
// freezes the whole pipeline without losing or repeating anything.
module depth_pixel_quantizer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [dpq_pkg::RAW_W-1:0]            raw_sample,
	input  logic                                 last_pixel,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [dpq_pkg::CODE_W-1:0]           code,
	output logic [2:0]                           status,
	output logic                                 frame_end,
	input  logic                                 cfg_we,
	input  logic [dpq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dpq_pkg::CFG_W-1:0]            cfg_data
);

	localparam int DW  = dpq_pkg::D_W;
	localparam int XW  = dpq_pkg::X_W;
	localparam int LW  = dpq_pkg::L_W;
	localparam int DNW = dpq_pkg::DEN_W;
	localparam int PW  = dpq_pkg::P_W;
	localparam int LL  = dpq_pkg::LOG_LAT;

	typedef struct packed {
		logic                 last;
		dpq_pkg::status_t     status;
		logic signed [DW-1:0] num;
		logic [DNW-1:0]       den;
	} side_t;

	// Configuration registers.
	logic        fmt_q;
	logic [31:0] lo_q;
	logic [31:0] hi_q;
	logic [31:0] off_q;
	logic        clip_q;
	logic        logm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= 1'b0;
			lo_q   <= 32'd0;
			hi_q   <= 32'd655360;
			off_q  <= 32'd0;
			clip_q <= 1'b1;
			logm_q <= 1'b0;
		end else if (cfg_we) begin
			case (dpq_pkg::cfg_index_t'(cfg_index))
				dpq_pkg::CFG_SOURCE_FORMAT: fmt_q  <= cfg_data[0];
				dpq_pkg::CFG_RANGE_LOW:     lo_q   <= cfg_data[31:0];
				dpq_pkg::CFG_RANGE_HIGH:    hi_q   <= cfg_data[31:0];
				dpq_pkg::CFG_LOG_OFFSET:    off_q  <= cfg_data[31:0];
				dpq_pkg::CFG_CLIP_ENABLE:   clip_q <= cfg_data[0];
				dpq_pkg::CFG_LOG_MODE:      logm_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances together and only freezes while the skid is full.
	logic skid_valid_q;
	logic en;
	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// Stages 1 and 2: raw sample to Q16.16 depth. Valid and frame marker ride alongside.
	logic                 v_s1, v_s2;
	logic                 last_s1, last_s2;
	logic signed [DW-1:0] depth_s2;
	logic                 nonfinite_s2;

	dpq_convert u_conv (
		.clk          (clk),
		.en           (en),
		.source_format(fmt_q),
		.raw_sample   (raw_sample),
		.depth_s2     (depth_s2),
		.nonfinite_s2 (nonfinite_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= last_pixel;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: range checks and the sums that feed the linear ratio and the log units.
	logic signed [DW-1:0] lo_d, hi_d, off_d, xv_c, num_c;
	logic signed [32:0]   lo_w, hi_w, off_w, x0_c, x1_c, den_c;
	dpq_pkg::status_t     st_c;

	assign lo_d  = $signed({{(DW-32){lo_q[31]}}, lo_q});
	assign hi_d  = $signed({{(DW-32){hi_q[31]}}, hi_q});
	assign off_d = $signed({{(DW-32){off_q[31]}}, off_q});
	assign lo_w  = $signed({lo_q[31], lo_q});
	assign hi_w  = $signed({hi_q[31], hi_q});
	assign off_w = $signed({off_q[31], off_q});
	assign xv_c  = depth_s2 + off_d;
	assign num_c = depth_s2 - lo_d;
	assign x0_c  = lo_w + off_w;
	assign x1_c  = hi_w + off_w;
	assign den_c = hi_w - lo_w;

	// The checks are prioritised exactly in the order of the status codes.
	always_comb begin
		st_c = dpq_pkg::ST_OK;
		if (nonfinite_s2)
			st_c = dpq_pkg::ST_NONFINITE;
		else if (!clip_q && (depth_s2 < lo_d || depth_s2 > hi_d))
			st_c = dpq_pkg::ST_RANGE;
		else if (logm_q && xv_c <= 0)
			st_c = dpq_pkg::ST_LOGARG;
		else if ($signed(hi_q) <= $signed(lo_q))
			st_c = dpq_pkg::ST_BADRANGE;
		else if (logm_q && x0_c <= 0)
			st_c = dpq_pkg::ST_BADRANGE;
	end

	logic          v_s3;
	side_t         side_s3;
	logic [XW-1:0] xv_s3, x0_s3, x1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.last   <= last_s2;
			side_s3.status <= st_c;
			side_s3.num    <= num_c;
			side_s3.den    <= {{(DNW-33){1'b0}}, den_c};
			xv_s3          <= xv_c;
			x0_s3          <= {{(XW-33){x0_c[32]}}, x0_c};
			x1_s3          <= {{(XW-33){x1_c[32]}}, x1_c};
		end
	end

	// Log units for the pixel and both bounds. Arguments that are not positive only
	// occur on pixels that already carry an error status, so their logs are never used.
	logic [LW-1:0] lg_v, lg_0, lg_1;

	dpq_log2 u_log_v (.clk(clk), .en(en), .arg(xv_s3), .lg(lg_v));
	dpq_log2 u_log_0 (.clk(clk), .en(en), .arg(x0_s3), .lg(lg_0));
	dpq_log2 u_log_1 (.clk(clk), .en(en), .arg(x1_s3), .lg(lg_1));

	// Delay line that keeps the per-pixel data level with the log units.
	side_t side_q [1:LL];
	logic  sv_q   [1:LL];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[1] <= side_s3;
			for (int i = 2; i <= LL; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LL; i++)
				sv_q[i] <= 1'b0;
		end else if (en) begin
			sv_q[1] <= v_s3;
			for (int i = 2; i <= LL; i++)
				sv_q[i] <= sv_q[i-1];
		end
	end

	// Stage 4 (after the log units): pick the linear or logarithmic ratio.
	logic signed [LW:0]   ldiff_c;
	logic [LW-1:0]        lden_c;
	logic                 lbad_c;
	logic signed [DW-1:0] rnum_c;
	logic [DNW-1:0]       rden_c;
	dpq_pkg::status_t     st4_c;

	assign ldiff_c = $signed({1'b0, lg_v}) - $signed({1'b0, lg_0});
	assign lden_c  = lg_1 - lg_0;
	assign lbad_c  = lg_1 <= lg_0;

	always_comb begin
		st4_c = side_q[LL].status;
		if (logm_q) begin
			rnum_c = $signed({{(DW-LW-1){ldiff_c[LW]}}, ldiff_c});
			rden_c = DNW'(lden_c);
			if (st4_c == dpq_pkg::ST_OK && lbad_c)
				st4_c = dpq_pkg::ST_BADRANGE;
		end else begin
			rnum_c = side_q[LL].num;
			rden_c = side_q[LL].den;
		end
	end

	logic                 v_s4, last_s4;
	logic signed [DW-1:0] num_s4;
	logic [DNW-1:0]       den_s4;
	dpq_pkg::status_t     st_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= sv_q[LL];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s4 <= side_q[LL].last;
			num_s4  <= rnum_c;
			den_s4  <= rden_c;
			st_s4   <= st4_c;
		end
	end

	// Stage 5: clamp to 0..1 and scale the numerator by the largest code.
	dpq_pkg::code_kind_t kind_c;
	logic [PW-1:0]       prod_c;

	always_comb begin
		if (num_s4 <= 0)
			kind_c = dpq_pkg::CK_ZERO;
		else if (num_s4 >= $signed({{(DW-DNW){1'b0}}, den_s4}))
			kind_c = dpq_pkg::CK_FULL;
		else
			kind_c = dpq_pkg::CK_DIV;
	end

	assign prod_c = PW'(num_s4[DNW-1:0]) * PW'(dpq_pkg::CODE_MAX);

	logic           v_s5;
	dpq_pkg::tag_t  tag_s5;
	logic [PW-1:0]  prod_s5;
	logic [DNW-1:0] den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s5.last   <= last_s4;
			tag_s5.status <= st_s4;
			tag_s5.kind   <= kind_c;
			prod_s5       <= prod_c;
			den_s5        <= den_s4;
		end
	end

	// Division of the scaled numerator by the range, rounded half to even.
	logic          div_vld;
	dpq_pkg::res_t div_res;

	dpq_divide u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (v_s5),
		.tag    (tag_s5),
		.prod   (prod_s5),
		.den    (den_s5),
		.res_vld(div_vld),
		.res    (div_res)
	);

	// Output register with a one-entry skid behind it.
	logic          out_valid_q;
	dpq_pkg::res_t out_res_q;
	dpq_pkg::res_t skid_res_q;
	logic          load_out;
	logic          load_skid;

	assign load_out  = en ? (div_vld && (!out_valid_q || !out_stall)) : !out_stall;
	assign load_skid = en && div_vld && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en) begin
			if (div_vld) begin
				if (!out_valid_q || !out_stall)
					out_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end else if (!out_stall) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_res_q <= en ? div_res : skid_res_q;
		if (load_skid)
			skid_res_q <= div_res;
	end

	assign out_valid = out_valid_q;
	assign code      = out_res_q.code;
	assign status    = out_res_q.status;
	assign frame_end = out_res_q.last;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_stall |=> !skid_valid_q)
		else $error("skid register did not drain when the receiver took the output");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> $stable(v_s5) && $stable(v_s1))
		else $error("pipeline moved while the skid register was full");

	a_error_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_res_q.status != dpq_pkg::ST_OK |-> out_res_q.code == '0)
		else $error("flagged pixel carries a non-zero code");

endmodule

>>> hw/rtl/dpq_convert.sv
// Two-stage conversion of a raw sample (millimetres or binary32 metres) to Q16.16.
// Depends on dpq_pkg.
module dpq_convert (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic                                 source_format,
	input  logic [dpq_pkg::RAW_W-1:0]            raw_sample,
	output logic signed [dpq_pkg::D_W-1:0]       depth_s2,
	output logic                                 nonfinite_s2
);

	localparam int DW = dpq_pkg::D_W;
	localparam int MW = dpq_pkg::MAG_W;
	// floor(x / 125) = (x * ceil(2^36 / 125)) >> 36 for every x below 2^29.
	localparam logic [29:0] MM_RECIP = 30'd549755814;

	logic [29:0] mm_x;
	logic [59:0] mm_prod;
	logic [7:0]  f_exp;
	logic [23:0] f_sig;
	logic [7:0]  f_sh;
	logic [MW-1:0] f_mag;
	logic [47:0] f_ext;
	logic [23:0] f_q;
	logic        f_up;

	logic          fmt_s1;
	logic          sign_s1;
	logic          nonfinite_s1;
	logic [23:0]   mm_s1;
	logic [MW-1:0] mag_s1;

	assign mm_x    = {1'b0, raw_sample[15:0], 13'd0} + 30'd62;
	assign mm_prod = 60'(mm_x) * 60'(MM_RECIP);
	assign f_exp   = raw_sample[30:23];
	assign f_sig   = {1'b1, raw_sample[22:0]};

	always_comb begin
		f_sh  = 8'd0;
		f_ext = '0;
		f_q   = '0;
		f_up  = 1'b0;
		f_mag = '0;
		if (f_exp == 8'd0 || f_exp == 8'hFF) begin
			f_mag = '0;
		end else if (f_exp >= 8'd134) begin
			f_sh = f_exp - 8'd134;
			if (f_sh > 8'd22)
				f_mag = MW'(1) << (MW - 1);
			else
				f_mag = MW'(f_sig) << f_sh[4:0];
		end else begin
			f_sh = 8'd134 - f_exp;
			if (f_sh <= 8'd24) begin
				f_ext = {f_sig, 24'd0} >> f_sh[4:0];
				f_q   = f_ext[47:24];
				f_up  = f_ext[23] & ((|f_ext[22:0]) | f_q[0]);
				f_mag = MW'(f_q) + MW'(f_up);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fmt_s1       <= source_format;
			sign_s1      <= raw_sample[31];
			nonfinite_s1 <= source_format & (f_exp == 8'hFF);
			mm_s1        <= mm_prod[59:36];
			mag_s1       <= f_mag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nonfinite_s2 <= nonfinite_s1;
			if (!fmt_s1)
				depth_s2 <= $signed(DW'(mm_s1));
			else if (sign_s1)
				depth_s2 <= -$signed(DW'(mag_s1));
			else
				depth_s2 <= $signed(DW'(mag_s1));
		end
	end

endmodule

>>> hw/rtl/dpq_log2.sv
// Pipelined fixed-point log2: leading-one search, normalise, then one squaring per stage.
// Depends on dpq_pkg.
module dpq_log2 (
	input  logic                       clk,
	input  logic                       en,
	input  logic [dpq_pkg::X_W-1:0]    arg,
	output logic [dpq_pkg::L_W-1:0]    lg
);

	localparam int XW = dpq_pkg::X_W;
	localparam int NW = dpq_pkg::N_W;
	localparam int LF = dpq_pkg::LOG_FRAC;

	logic [NW-1:0]      n_c;
	logic [XW-1:0]      arg_s1;
	logic [NW-1:0]      n_s1;
	logic [XW+30:0]     norm_c;

	logic [31:0]        sq_m_s [0:LF];
	logic [LF-1:0]      sq_f_s [0:LF];
	logic [NW-1:0]      sq_n_s [0:LF];

	always_comb begin
		n_c = '0;
		for (int i = 0; i < XW; i++) begin
			if (arg[i])
				n_c = NW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s1 <= arg;
			n_s1   <= n_c;
		end
	end

	// Shifting x left by 31 and right by n puts the leading one at bit 31.
	assign norm_c = {arg_s1, 31'd0} >> n_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_m_s[0] <= norm_c[31:0];
			sq_f_s[0] <= '0;
			sq_n_s[0] <= n_s1;
		end
	end

	for (genvar k = 0; k < LF; k++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] t;
		assign sq = 64'(sq_m_s[k]) * 64'(sq_m_s[k]);
		assign t  = sq[63:31];
		always_ff @(posedge clk) begin
			if (en) begin
				sq_m_s[k+1] <= t[32] ? t[32:1] : t[31:0];
				sq_f_s[k+1] <= {sq_f_s[k][LF-2:0], t[32]};
				sq_n_s[k+1] <= sq_n_s[k];
			end
		end
	end

	assign lg = {sq_n_s[LF], sq_f_s[LF]};

endmodule

>>> hw/rtl/dpq_divide.sv
// Pipelined restoring divider (one quotient bit per stage) with half-to-even rounding.
// Depends on dpq_pkg.
module dpq_divide (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  dpq_pkg::tag_t               tag,
	input  logic [dpq_pkg::P_W-1:0]     prod,
	input  logic [dpq_pkg::DEN_W-1:0]   den,
	output logic                        res_vld,
	output dpq_pkg::res_t               res
);

	localparam int PW = dpq_pkg::P_W;
	localparam int DNW = dpq_pkg::DEN_W;
	localparam int CB = dpq_pkg::CODE_BITS;
	localparam int CW = dpq_pkg::CODE_W;
	localparam int LS = CB - 1;

	logic [PW-1:0]     rem_s [0:CB-1];
	logic [DNW-1:0]    den_s [0:CB-1];
	logic [CB-1:0]     q_s   [0:CB-1];
	dpq_pkg::tag_t     tag_s [0:CB-1];
	logic              v_s   [0:CB-1];

	for (genvar k = 0; k < CB; k++) begin : g_step
		logic [PW-1:0]  rem_in;
		logic [PW-1:0]  trial;
		logic [DNW-1:0] den_in;
		logic [CB-1:0]  q_in;
		dpq_pkg::tag_t  tag_in;
		logic           v_in;
		logic           take;
		if (k == 0) begin : g_first
			assign rem_in = prod;
			assign den_in = den;
			assign q_in   = '0;
			assign tag_in = tag;
			assign v_in   = in_vld;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
			assign tag_in = tag_s[k-1];
			assign v_in   = v_s[k-1];
		end
		assign trial = PW'(den_in) << (CB - 1 - k);
		assign take  = rem_in >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? rem_in - trial : rem_in;
				den_s[k] <= den_in;
				q_s[k]   <= {q_in[CB-2:0], take};
				tag_s[k] <= tag_in;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= v_in;
		end
	end

	logic [PW:0]      two_r;
	logic [PW:0]      den_x;
	logic             up;
	logic [CB-1:0]    q_rnd;
	logic [CB-1:0]    code_cb;
	logic [CB+CW-1:0] code_x;
	dpq_pkg::res_t    res_q;
	logic             res_vld_q;

	assign two_r = {rem_s[LS], 1'b0};
	assign den_x = (PW + 1)'(den_s[LS]);
	assign up    = (two_r > den_x) || ((two_r == den_x) && q_s[LS][0]);
	assign q_rnd = q_s[LS] + CB'(up);

	always_comb begin
		case (tag_s[LS].kind)
			dpq_pkg::CK_ZERO: code_cb = '0;
			dpq_pkg::CK_FULL: code_cb = dpq_pkg::CODE_MAX;
			dpq_pkg::CK_DIV:  code_cb = q_rnd;
			default:          code_cb = '0;
		endcase
		if (tag_s[LS].status != dpq_pkg::ST_OK)
			code_cb = '0;
	end

	assign code_x = {{CW{1'b0}}, code_cb};

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.code   <= code_x[CW-1:0];
			res_q.status <= tag_s[LS].status;
			res_q.last   <= tag_s[LS].last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else if (en)
			res_vld_q <= v_s[LS];
	end

	assign res_vld = res_vld_q;
	assign res     = res_q;

endmodule
